// ----- sv/rmcv_pkg.sv -----
package rmcv_pkg;

  localparam int unsigned SQ_W   = 64;
  localparam int unsigned ROOT_W = SQ_W / 2;
  localparam int unsigned DIV_W  = 64;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD0,
    S_LD1,
    S_LD2,
    S_LD3,
    S_DIFF,
    S_MUL,
    S_TAKE,
    S_SQRT,
    S_CDIV,
    S_FIN,
    S_FDIV,
    S_DONE
  } rmcv_state_e;

  // multiply slots of one neighbor step
  typedef enum logic [3:0] {
    MI_C0A, MI_C0B, MI_C1A, MI_C1B, MI_C2A, MI_C2B,
    MI_D0, MI_D1, MI_D2,
    MI_S0, MI_S1, MI_S2,
    MI_W0, MI_W1, MI_W2
  } mul_slot_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SHORT,
    ST_DEGEN,
    ST_OVF
  } status_e;

  typedef enum logic {
    CMD_CENTRE,
    CMD_NEIGHBOR
  } cmd_e;

  function automatic logic signed [63:0] sx(input logic signed [31:0] v);
    return 64'(v);
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return !((&v[63:31]) || !(|v[63:31]));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (!ovf32(v)) begin
      r = v[31:0];
    end else if (v[63]) begin
      r = {1'b1, {31{1'b0}}};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- sv/rmcv_sqrt.sv -----
module rmcv_sqrt
  import rmcv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   radicand_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam logic [SQ_W-1:0] BitInit = SQ_W'(1) << (SQ_W - 2);

  logic [SQ_W-1:0] v_q, r_q, b_q;
  logic            busy_q, done_q;
  logic [SQ_W:0]   rb;
  logic            ge;

  assign rb     = {1'b0, r_q} + {1'b0, b_q};
  assign ge     = {1'b0, v_q} >= rb;
  assign done_o = done_q;
  assign root_o = r_q[ROOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && b_q[0];
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && b_q[0]) begin
        busy_q <= 1'b0;
      end
    end
  end

  // one result bit per cycle, two radicand bits consumed
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= radicand_i;
      r_q <= '0;
      b_q <= BitInit;
    end else if (busy_q) begin
      if (ge) begin
        v_q <= v_q - rb[SQ_W-1:0];
        r_q <= (r_q >> 1) + b_q;
      end else begin
        r_q <= r_q >> 1;
      end
      b_q <= b_q >> 2;
    end
  end

endmodule

// ----- sv/rmcv_div.sv -----
module rmcv_div
  import rmcv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DIV_W);

  logic [DIV_W-1:0] rem_q, quo_q, div_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DIV_W:0]   rem_s, rem_n;
  logic             ge;

  assign rem_s      = {rem_q, quo_q[DIV_W-1]};
  assign ge         = rem_s >= {1'b0, div_q};
  assign rem_n      = ge ? rem_s - {1'b0, div_q} : rem_s;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == '0)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // restoring, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
      cnt_q <= CntW'(DIV_W - 1);
    end else if (busy_q) begin
      rem_q <= rem_n[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
      cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

// ----- sv/ring_mean_curvature_vector.sv -----
// Channel | Direction | Handshake              | Payload
// in      | into      | in_valid_i / in_ready_o | cmd_i coord_x_i coord_y_i coord_z_i last_i
// out     | out of    | out_valid_o/ out_ready_i| curv_x_o curv_y_o curv_z_o status_o
//
// Centre and non-closing neighbor items are taken directly in idle. A closing item
// starts the ring pass: for each stored neighbor, loads, differences and products
// run and the 32-step square root and 64-step divider are used twice, then the
// final scaling uses the divider once per axis. Short rings skip the pass.
// Reset clears centre, ring count and control; the ring memory is not cleared.
// in_ready_o is low for the whole pass; a held result stalls only the final
// store, and a new item is taken while the previous result waits.
module ring_mean_curvature_vector
  import rmcv_pkg::*;
#(
  parameter int unsigned MAX_RING  = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] curv_x_o,
  output logic signed [31:0] curv_y_o,
  output logic signed [31:0] curv_z_o,
  output logic [1:0]         status_o
);

  localparam int unsigned CntW  = $clog2(MAX_RING + 1);
  localparam int unsigned AddrW = $clog2(MAX_RING);
  localparam int unsigned AreaW = 33 + $clog2(MAX_RING);

  rmcv_state_e state_q, state_d;

  // ring store, x/y/z packed
  logic [95:0]        ring_mem [MAX_RING];
  logic [95:0]        rd_q;
  logic [AddrW-1:0]   rd_addr;

  logic signed [31:0] centre_q [3];
  logic [CntW-1:0]    count_q, count_n;
  logic               ovf_q, ovf_n;
  logic               out_valid_q;

  logic               short_q, flag_q, half_q, neg_q;
  logic [AddrW-1:0]   j_q, jp, jn;
  logic               j_last;
  mul_slot_e          idx_q;
  logic [1:0]         k_q;

  logic signed [31:0] vp_q [3], vj_q [3], vn_q [3];
  logic signed [31:0] ej_q [3], ep_q [3], en_q [3], op_q [3], on_q [3];
  logic signed [31:0] c_q [3];
  logic signed [31:0] d_q, cot1_q, cs_q;
  logic signed [63:0] acc_q [3];
  logic signed [63:0] tmp_q, prod_q;
  logic [SQ_W-1:0]    sq_q, sq_next;
  logic [AreaW-1:0]   area_q;
  logic signed [31:0] res_q [3];
  logic signed [31:0] curv_q [3];
  status_e            status_q;

  logic               in_fire, out_fire;
  logic signed [31:0] a_sel [3], b_sel [3];
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod_d, fs, diff_t, sum_t;

  logic               sq_start, sq_done;
  logic [ROOT_W-1:0]  root;
  logic               div_start, div_done;
  logic [DIV_W-1:0]   dividend, divisor, quotient;
  logic signed [63:0] q_signed, dabs, fin_abs;
  logic signed [31:0] fin_a, cot_val;
  logic               cot_fire, cot_flag;
  logic signed [63:0] cs_sum;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_fire    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign curv_x_o    = curv_q[0];
  assign curv_y_o    = curv_q[1];
  assign curv_z_o    = curv_q[2];
  assign status_o    = status_q;

  // ring count after the incoming item
  always_comb begin
    count_n = count_q;
    ovf_n   = ovf_q;
    if (cmd_e'(cmd_i) == CMD_CENTRE) begin
      count_n = '0;
      ovf_n   = 1'b0;
    end else if (count_q < CntW'(MAX_RING)) begin
      count_n = count_q + CntW'(1);
    end else begin
      ovf_n = 1'b1;
    end
  end

  // neighbor indices, cyclic
  always_comb begin
    logic [CntW-1:0] cm1;
    cm1    = count_q - CntW'(1);
    j_last = (CntW'(j_q) + CntW'(1)) == count_q;
    jp     = (j_q == '0) ? cm1[AddrW-1:0] : j_q - AddrW'(1);
    jn     = j_last ? '0 : j_q + AddrW'(1);
    case (state_q)
      S_LD0:   rd_addr = jp;
      S_LD1:   rd_addr = j_q;
      default: rd_addr = jn;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_sel[k] = half_q ? en_q[k] : op_q[k];
      b_sel[k] = half_q ? on_q[k] : ep_q[k];
    end
    case (idx_q)
      MI_C0A:  begin ma = a_sel[1]; mb = b_sel[2]; end
      MI_C0B:  begin ma = a_sel[2]; mb = b_sel[1]; end
      MI_C1A:  begin ma = a_sel[2]; mb = b_sel[0]; end
      MI_C1B:  begin ma = a_sel[0]; mb = b_sel[2]; end
      MI_C2A:  begin ma = a_sel[0]; mb = b_sel[1]; end
      MI_C2B:  begin ma = a_sel[1]; mb = b_sel[0]; end
      MI_D0:   begin ma = a_sel[0]; mb = b_sel[0]; end
      MI_D1:   begin ma = a_sel[1]; mb = b_sel[1]; end
      MI_D2:   begin ma = a_sel[2]; mb = b_sel[2]; end
      MI_S0:   begin ma = c_q[0];   mb = c_q[0];   end
      MI_S1:   begin ma = c_q[1];   mb = c_q[1];   end
      MI_S2:   begin ma = c_q[2];   mb = c_q[2];   end
      MI_W0:   begin ma = ej_q[0];  mb = cs_q;     end
      MI_W1:   begin ma = ej_q[1];  mb = cs_q;     end
      default: begin ma = ej_q[2];  mb = cs_q;     end
    endcase
  end

  assign prod_d  = ma * mb;
  assign fs      = prod_q >>> FRAC_BITS;   // floor shift
  assign diff_t  = tmp_q - fs;
  assign sum_t   = tmp_q + fs;
  assign sq_next = sq_q + SQ_W'(unsigned'(prod_q));

  assign sq_start = (state_q == S_TAKE) && (idx_q == MI_S2);

  rmcv_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sq_next),
    .done_o     (sq_done),
    .root_o     (root)
  );

  // divider operands: cotangent or final scaling
  always_comb begin
    dabs    = d_q[31] ? -sx(d_q) : sx(d_q);
    fin_a   = sat32(acc_q[k_q]);
    fin_abs = fin_a[31] ? -sx(fin_a) : sx(fin_a);
    if (state_q == S_FIN) begin
      dividend  = DIV_W'((fin_abs + (fin_abs <<< 1)) <<< FRAC_BITS);
      divisor   = DIV_W'({area_q, 1'b0});
      div_start = (area_q != '0);
    end else begin
      dividend  = DIV_W'(dabs <<< FRAC_BITS);
      divisor   = DIV_W'(root);
      div_start = (state_q == S_SQRT) && sq_done && (root != '0);
    end
  end

  rmcv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign q_signed = neg_q ? -signed'(quotient) : signed'(quotient);

  // cotangent ready: zero-area triangle or divide finished
  always_comb begin
    cot_fire = 1'b0;
    cot_val  = sat32(q_signed);
    cot_flag = ovf32(q_signed);
    if ((state_q == S_SQRT) && sq_done && (root == '0)) begin
      cot_fire = 1'b1;
      cot_val  = '0;
      cot_flag = 1'b1;
    end else if ((state_q == S_CDIV) && div_done) begin
      cot_fire = 1'b1;
    end
    cs_sum = sx(cot1_q) + sx(cot_val);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && last_i) begin
          state_d = (count_n < CntW'(3)) ? S_DONE : S_LD0;
        end
      end
      S_LD0:  state_d = S_LD1;
      S_LD1:  state_d = S_LD2;
      S_LD2:  state_d = S_LD3;
      S_LD3:  state_d = S_DIFF;
      S_DIFF: state_d = S_MUL;
      S_MUL:  state_d = S_TAKE;
      S_TAKE: begin
        if (idx_q == MI_S2) begin
          state_d = S_SQRT;
        end else if (idx_q == MI_W2) begin
          state_d = j_last ? S_FIN : S_LD0;
        end else begin
          state_d = S_MUL;
        end
      end
      S_SQRT: begin
        if (cot_fire) begin
          state_d = S_MUL;
        end else if (sq_done) begin
          state_d = S_CDIV;
        end
      end
      S_CDIV: begin
        if (cot_fire) begin
          state_d = S_MUL;
        end
      end
      S_FIN:  state_d = (area_q == '0) ? S_DONE : S_FDIV;
      S_FDIV: begin
        if (div_done) begin
          state_d = (k_q == 2'd2) ? S_DONE : S_FIN;
        end
      end
      S_DONE: begin
        if (out_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) centre_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        count_q <= count_n;
        ovf_q   <= ovf_n;
        if (cmd_e'(cmd_i) == CMD_CENTRE) begin
          centre_q[0] <= coord_x_i;
          centre_q[1] <= coord_y_i;
          centre_q[2] <= coord_z_i;
        end
      end
      if (out_fire) begin
        count_q     <= '0;
        ovf_q       <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_fire && (cmd_e'(cmd_i) == CMD_NEIGHBOR) && (count_q < CntW'(MAX_RING))) begin
      ring_mem[count_q[AddrW-1:0]] <= {coord_x_i, coord_y_i, coord_z_i};
    end
    rd_q <= ring_mem[rd_addr];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (state_q)
      S_IDLE: begin
        if (in_fire && last_i) begin
          short_q <= (count_n < CntW'(3));
          flag_q  <= 1'b0;
          area_q  <= '0;
          j_q     <= '0;
          half_q  <= 1'b0;
          idx_q   <= MI_C0A;
          k_q     <= '0;
          for (int k = 0; k < 3; k++) begin
            acc_q[k] <= '0;
            res_q[k] <= '0;
          end
        end
      end
      S_LD1: {vp_q[0], vp_q[1], vp_q[2]} <= rd_q;
      S_LD2: {vj_q[0], vj_q[1], vj_q[2]} <= rd_q;
      S_LD3: {vn_q[0], vn_q[1], vn_q[2]} <= rd_q;
      S_DIFF: begin
        logic f;
        f = flag_q;
        for (int k = 0; k < 3; k++) begin
          ej_q[k] <= sat32(sx(vj_q[k]) - sx(centre_q[k]));
          ep_q[k] <= sat32(sx(vp_q[k]) - sx(centre_q[k]));
          en_q[k] <= sat32(sx(vn_q[k]) - sx(centre_q[k]));
          op_q[k] <= sat32(sx(vj_q[k]) - sx(vp_q[k]));
          on_q[k] <= sat32(sx(vj_q[k]) - sx(vn_q[k]));
          f = f | ovf32(sx(vj_q[k]) - sx(centre_q[k]))
                | ovf32(sx(vp_q[k]) - sx(centre_q[k]))
                | ovf32(sx(vn_q[k]) - sx(centre_q[k]))
                | ovf32(sx(vj_q[k]) - sx(vp_q[k]))
                | ovf32(sx(vj_q[k]) - sx(vn_q[k]));
        end
        flag_q <= f;
      end
      S_TAKE: begin
        case (idx_q)
          MI_C0A, MI_C1A, MI_C2A, MI_D0: tmp_q <= fs;
          MI_C0B: begin c_q[0] <= sat32(diff_t); flag_q <= flag_q | ovf32(diff_t); end
          MI_C1B: begin c_q[1] <= sat32(diff_t); flag_q <= flag_q | ovf32(diff_t); end
          MI_C2B: begin c_q[2] <= sat32(diff_t); flag_q <= flag_q | ovf32(diff_t); end
          MI_D1:  tmp_q <= sum_t;
          MI_D2:  begin d_q <= sat32(sum_t); flag_q <= flag_q | ovf32(sum_t); end
          MI_S0:  sq_q <= SQ_W'(unsigned'(prod_q));
          MI_S1, MI_S2: sq_q <= sq_next;
          MI_W0:  acc_q[0] <= acc_q[0] + fs;
          MI_W1:  acc_q[1] <= acc_q[1] + fs;
          default: acc_q[2] <= acc_q[2] + fs;
        endcase
        if (idx_q == MI_W2) begin
          j_q    <= j_q + AddrW'(1);
          half_q <= 1'b0;
          idx_q  <= MI_C0A;
        end else if (idx_q != MI_S2) begin
          idx_q <= mul_slot_e'(idx_q + 4'd1);
        end
      end
      S_SQRT, S_CDIV: begin
        if (sq_done && (state_q == S_SQRT)) begin
          neg_q <= d_q[31];
        end
        if (cot_fire) begin
          if (!half_q) begin
            area_q <= area_q + AreaW'(root);
            cot1_q <= cot_val;
            half_q <= 1'b1;
            idx_q  <= MI_C0A;
            flag_q <= flag_q | cot_flag;
          end else begin
            cs_q   <= sat32(cs_sum);
            idx_q  <= MI_W0;
            flag_q <= flag_q | cot_flag | ovf32(cs_sum);
          end
        end
      end
      S_FIN: begin
        neg_q  <= (fin_a > 0);
        flag_q <= flag_q | ovf32(acc_q[k_q]) | (area_q == '0);
      end
      S_FDIV: begin
        if (div_done) begin
          res_q[k_q] <= sat32(q_signed);
          flag_q     <= flag_q | ovf32(q_signed);
          k_q        <= k_q + 2'd1;
        end
      end
      S_DONE: begin
        if (out_fire) begin
          for (int k = 0; k < 3; k++) curv_q[k] <= res_q[k];
          if (short_q) begin
            status_q <= ST_SHORT;
          end else if (ovf_q) begin
            status_q <= ST_OVF;
          end else if (flag_q) begin
            status_q <= ST_DEGEN;
          end else begin
            status_q <= ST_OK;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- bench/tb_ring_mean_curvature_vector.sv -----
module tb_ring_mean_curvature_vector
  import rmcv_pkg::*;
;

  localparam int unsigned RING_CAP   = 32;
  localparam int unsigned FRAC       = 16;
  localparam int unsigned CYC_LIMIT  = 1500000;
  localparam int unsigned ITEM_GOAL  = 450;
  localparam int unsigned TAIL_WAIT  = 60;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] PMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] NMAX = 32'sh8000_0000;

  typedef longint vec3_t[3];

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    status_e            st;
  } curv_t;

  typedef struct {
    cmd_e               cmd;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
    logic               typed;   // expected result typed in below
    curv_t              want;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               cmd_i = 1'b0;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_y_i = '0;
  logic signed [31:0] coord_z_i = '0;
  logic               last_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] curv_x_o;
  logic signed [31:0] curv_y_o;
  logic signed [31:0] curv_z_o;
  logic [1:0]         status_o;

  ring_mean_curvature_vector dut (.*);

  // 10-unit clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int unsigned cycles;
  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned idle_pct;
  int unsigned stall_pct;
  curv_t       curv_q[$];

  // --- predictor state: centre, stored neighbors, ring fill, drop flag ---
  logic signed [31:0] ctr_x, ctr_y, ctr_z;
  logic signed [31:0] nb_x[RING_CAP];
  logic signed [31:0] nb_y[RING_CAP];
  logic signed [31:0] nb_z[RING_CAP];
  int unsigned        nb_cnt;
  bit                 nb_dropped;

  function automatic longint clamp32(longint v, inout bit flag);
    if (v > longint'(PMAX)) begin
      flag = 1'b1;
      return longint'(PMAX);
    end
    if (v < longint'(NMAX)) begin
      flag = 1'b1;
      return longint'(NMAX);
    end
    return v;
  endfunction

  // fixed-point product, floor toward minus infinity
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // dot(a,b)/|a x b| in fixed point; |a x b| returned through nrm
  function automatic longint cot_ratio(vec3_t a, vec3_t b, output longint nrm,
                                       inout bit flag);
    longint c0, c1, c2, d;
    longint unsigned sq;
    c0 = clamp32(qmul(a[1], b[2]) - qmul(a[2], b[1]), flag);
    c1 = clamp32(qmul(a[2], b[0]) - qmul(a[0], b[2]), flag);
    c2 = clamp32(qmul(a[0], b[1]) - qmul(a[1], b[0]), flag);
    sq = longint'(c0 * c0) + longint'(c1 * c1) + longint'(c2 * c2);
    nrm = longint'(int_sqrt(sq));
    d = clamp32(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]), flag);
    if (nrm == 0) begin
      flag = 1'b1;
      return 0;
    end
    return clamp32((d * (longint'(1) << FRAC)) / nrm, flag);
  endfunction

  function automatic curv_t ring_curvature();
    curv_t  r;
    bit     flag;
    longint acc[3];
    longint area;
    longint n1, n2, cs;
    vec3_t  vj, vp, vn, ej, ep, en, op, on, ctr;
    int     jp, jn, n;
    flag = 1'b0;
    r.x = '0;
    r.y = '0;
    r.z = '0;
    n = int'(nb_cnt);
    if (n < 3) begin
      r.st = ST_SHORT;
      return r;
    end
    acc = '{0, 0, 0};
    area = 0;
    ctr = '{ctr_x, ctr_y, ctr_z};
    for (int j = 0; j < n; j++) begin
      jp = (j + n - 1) % n;
      jn = (j + 1) % n;
      vj = '{nb_x[j], nb_y[j], nb_z[j]};
      vp = '{nb_x[jp], nb_y[jp], nb_z[jp]};
      vn = '{nb_x[jn], nb_y[jn], nb_z[jn]};
      for (int k = 0; k < 3; k++) begin
        ej[k] = clamp32(vj[k] - ctr[k], flag);
        ep[k] = clamp32(vp[k] - ctr[k], flag);
        en[k] = clamp32(vn[k] - ctr[k], flag);
        op[k] = clamp32(vj[k] - vp[k], flag);
        on[k] = clamp32(vj[k] - vn[k], flag);
      end
      cs = cot_ratio(op, ep, n1, flag);
      area += n1;
      cs = clamp32(cs + cot_ratio(en, on, n2, flag), flag);
      for (int k = 0; k < 3; k++) acc[k] += qmul(ej[k], cs);
    end
    if (area == 0) begin
      flag = 1'b1;
    end else begin
      for (int k = 0; k < 3; k++) begin
        longint a;
        a = clamp32(acc[k], flag);
        acc[k] = clamp32((-a * 3 * (longint'(1) << FRAC)) / (2 * area), flag);
      end
      r.x = acc[0][31:0];
      r.y = acc[1][31:0];
      r.z = acc[2][31:0];
    end
    r.st = nb_dropped ? ST_OVF : (flag ? ST_DEGEN : ST_OK);
    return r;
  endfunction

  // advance predictor by one accepted item; true if it closes a ring
  function automatic bit ring_step(cmd_e cmd, logic signed [31:0] x,
                                   logic signed [31:0] y, logic signed [31:0] z,
                                   logic last, output curv_t res);
    if (cmd == CMD_CENTRE) begin
      ctr_x = x;
      ctr_y = y;
      ctr_z = z;
      nb_cnt = 0;
      nb_dropped = 1'b0;
    end else if (nb_cnt < RING_CAP) begin
      nb_x[nb_cnt] = x;
      nb_y[nb_cnt] = y;
      nb_z[nb_cnt] = z;
      nb_cnt++;
    end else begin
      nb_dropped = 1'b1;
    end
    if (!last) return 1'b0;
    res = ring_curvature();
    nb_cnt = 0;
    nb_dropped = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch on result %0d: %s got %0h expected %0h",
             results_seen, what, got, want);
  endtask

  // drive one transfer; valid stays high into the next item unless idling
  task automatic send(cmd_e cmd, logic signed [31:0] x, logic signed [31:0] y,
                      logic signed [31:0] z, logic last, bit typed, curv_t want);
    curv_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    coord_x_i  <= x;
    coord_y_i  <= y;
    coord_z_i  <= z;
    last_i     <= last;
    do @(posedge clk_i); while (!in_ready_o);
    if (ring_step(cmd, x, y, z, last, res)) curv_q.push_back(typed ? want : res);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord(logic signed [31:0] base);
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? PMAX : NMAX;
      default: begin
        int unsigned span;
        span = 1 << $urandom_range(20, 12);
        return base + $signed($urandom_range(2 * span)) - $signed(span);
      end
    endcase
  endfunction

  // one ring of random content; mostly well formed, sometimes broken
  task automatic send_ring();
    logic signed [31:0] cx, cy, cz;
    int unsigned n;
    curv_t none;
    none = '{default: '0, st: ST_OK};
    cx = rand_coord(32'sd0);
    cy = rand_coord(32'sd0);
    cz = rand_coord(32'sd0);
    // neighbor-only ring reuses the previous centre
    if ($urandom_range(19) != 0) send(CMD_CENTRE, cx, cy, cz, 1'b0, 1'b0, none);
    case ($urandom_range(24))
      0:       n = $urandom_range(2, 0);
      1:       n = $urandom_range(RING_CAP + 4, RING_CAP);
      default: n = $urandom_range(8, 3);
    endcase
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(49) == 0)
        send(CMD_CENTRE, rand_coord(cx), rand_coord(cy), rand_coord(cz), 1'b0, 1'b0, none);
      send(CMD_NEIGHBOR, rand_coord(cx), rand_coord(cy), rand_coord(cz),
           i == n - 1, 1'b0, none);
    end
    // an empty ring closed by its own centre
    if (n == 0) send(CMD_CENTRE, cx, cy, cz, 1'b1, 1'b0, none);
  endtask

  // receiver: random stalls, checked at the rising edge
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (curv_q.size() == 0) begin
        report_mismatch("unexpected result, status", status_o, 0);
      end else begin
        curv_t w;
        w = curv_q.pop_front();
        if (curv_x_o !== w.x) report_mismatch("curv_x", curv_x_o, w.x);
        if (curv_y_o !== w.y) report_mismatch("curv_y", curv_y_o, w.y);
        if (curv_z_o !== w.z) report_mismatch("curv_z", curv_z_o, w.z);
        if (status_o !== w.st) report_mismatch("status", status_o, w.st);
      end
      results_seen++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  row_t rows[25];
  int unsigned phase_pct[5][2] = '{'{0, 0}, '{87, 0}, '{0, 87}, '{28, 28}, '{0, 0}};

  initial begin
    curv_t z0, zs, zd;
    z0 = '{default: '0, st: ST_OK};
    zs = '{default: '0, st: ST_SHORT};
    zd = '{default: '0, st: ST_DEGEN};
    rows = '{
      // lone neighbor around the reset centre: short ring
      '{CMD_NEIGHBOR, 0, 0, 0, 1, 1, zs},
      // centre that closes an empty ring
      '{CMD_CENTRE, PMAX, NMAX, 1, 1, 1, zs},
      '{CMD_CENTRE, 0, 0, 0, 0, 0, z0},
      '{CMD_NEIGHBOR, ONE, 0, 0, 0, 0, z0},
      '{CMD_NEIGHBOR, 0, ONE, 0, 1, 1, zs},
      // square pyramid apex
      '{CMD_CENTRE, 0, 0, ONE, 0, 0, z0},
      '{CMD_NEIGHBOR, ONE, 0, 0, 0, 0, z0},
      '{CMD_NEIGHBOR, 0, ONE, 0, 0, 0, z0},
      '{CMD_NEIGHBOR, -ONE, 0, 0, 0, 0, z0},
      '{CMD_NEIGHBOR, 0, -ONE, 0, 1, 0, z0},
      // everything on one point: zero area
      '{CMD_CENTRE, 5, 5, 5, 0, 0, z0},
      '{CMD_NEIGHBOR, 5, 5, 5, 0, 0, z0},
      '{CMD_NEIGHBOR, 5, 5, 5, 0, 0, z0},
      '{CMD_NEIGHBOR, 5, 5, 5, 1, 1, zd},
      // extremes, then a centre mid-ring that discards them
      '{CMD_CENTRE, 0, 0, 0, 0, 0, z0},
      '{CMD_NEIGHBOR, PMAX, PMAX, PMAX, 0, 0, z0},
      '{CMD_NEIGHBOR, NMAX, NMAX, NMAX, 0, 0, z0},
      '{CMD_NEIGHBOR, PMAX, NMAX, 0, 0, 0, z0},
      '{CMD_CENTRE, 1, 2, 3, 0, 0, z0},
      '{CMD_NEIGHBOR, PMAX, 0, NMAX, 0, 0, z0},
      '{CMD_NEIGHBOR, NMAX, PMAX, 0, 0, 0, z0},
      '{CMD_NEIGHBOR, 0, NMAX, PMAX, 1, 0, z0},
      // new ring around the same centre
      '{CMD_NEIGHBOR, ONE, 2 * ONE, 0, 0, 0, z0},
      '{CMD_NEIGHBOR, -ONE, ONE, ONE, 0, 0, z0},
      '{CMD_NEIGHBOR, 3 * ONE, -ONE, -ONE, 1, 0, z0}
    };
    ctr_x = '0;
    ctr_y = '0;
    ctr_z = '0;
    nb_cnt = 0;
    nb_dropped = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i])
      send(rows[i].cmd, rows[i].x, rows[i].y, rows[i].z, rows[i].last,
           rows[i].typed, rows[i].want);

    for (int p = 0; p < 5; p++) begin
      idle_pct  = phase_pct[p][0];
      stall_pct = phase_pct[p][1];
      while (items_sent < 25 + (p + 1) * (ITEM_GOAL - 25) / 5) send_ring();
      // hold off until the block has drained
      if (p == 2) begin
        in_valid_i <= 1'b0;
        wait (curv_q.size() == 0);
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    stall_pct = 0;
    wait (curv_q.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("%0d items sent, %0d curvature results checked over five idle/stall mixes",
             items_sent, results_seen);
    $display("rings covered: short, degenerate, saturated and overflowing; %0d cycles",
             cycles);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
